FILE: src/assert_macros.svh
// Assertion helpers; clk_i and rst_ni must be visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds on every clock edge out of reset.
`define WSD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("wsd assertion failed");

// Antecedent implies consequent in the same cycle.
`define WSD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wsd implication failed");

`endif

FILE: src/wsd_pkg.sv
package wsd_pkg;

  typedef enum logic [2:0] {
    PH_OPCODE  = 3'd0,
    PH_LENGTH  = 3'd1,
    PH_EXT     = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_CLOSE = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [3:0] EXT16_CNT = 4'd2;
  localparam logic [3:0] EXT64_CNT = 4'd8;
  localparam logic [3:0] MASK_CNT  = 4'd4;

  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] data;
    logic       last;
  } result_t;

endpackage

FILE: src/websocket_frame_deframer.sv
// Channel   Direction  Handshake          Payload
// in        sink       in_valid_i/in_stall_o   in_byte_i
// out       source     out_valid_o/out_stall_i kind_o, payload_byte_o, last_o
//
// Each byte passes the input register, then header/unmask logic into the
// result register. One byte per cycle sustained while out_stall_i is low.
// rst_ni is asynchronous; the parser starts out waiting for an opcode byte.
// An output stall holds a valid result and a full input register; in_stall_o rises
// only when the input register is full and the result register cannot drain.
module websocket_frame_deframer
  import wsd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] payload_byte_o,
  output logic       last_o
);

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       out_vld_q;
  result_t    out_res_q;
  result_t    res;
  logic       out_free;
  logic       step;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign in_stall_o = in_vld_q && !out_free;
  assign step       = in_vld_q && out_free;

  wsd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
      end
      if (out_free) begin
        out_vld_q <= step && res.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= in_byte_i;
    end
    if (step && res.valid) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign kind_o         = out_res_q.kind;
  assign payload_byte_o = out_res_q.data;
  assign last_o         = out_res_q.last;

endmodule

FILE: src/wsd_parser.sv
`include "assert_macros.svh"

module wsd_parser
  import wsd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output result_t    res_o
);

  phase_e      phase_q, phase_d;
  logic [3:0]  ext_cnt_q, ext_cnt_d;
  logic [63:0] len_q, len_d;      // remaining payload bytes
  logic [31:0] mkey_q, mkey_d;
  logic [1:0]  midx_q, midx_d;
  logic [7:0]  mbyte;

  assign mbyte = mkey_q[{~midx_q, 3'b000} +: 8];

  always_comb begin
    phase_d   = phase_q;
    ext_cnt_d = ext_cnt_q;
    len_d     = len_q;
    mkey_d    = mkey_q;
    midx_d    = midx_q;
    res_o     = '{valid: 1'b0, kind: KIND_DATA, data: 8'h00, last: 1'b0};
    if (step_i) begin
      case (phase_q)
        PH_LENGTH: begin
          len_d = '0;
          if (byte_i[6:0] == LEN_EXT16) begin
            ext_cnt_d = EXT16_CNT;
            phase_d   = PH_EXT;
          end else if (byte_i[6:0] == LEN_EXT64) begin
            ext_cnt_d = EXT64_CNT;
            phase_d   = PH_EXT;
          end else begin
            len_d     = {57'd0, byte_i[6:0]};
            ext_cnt_d = MASK_CNT;
            phase_d   = PH_MASK;
          end
        end
        PH_EXT: begin
          len_d     = {len_q[55:0], byte_i};
          ext_cnt_d = ext_cnt_q - 4'd1;
          if (ext_cnt_d == 4'd0) begin
            ext_cnt_d = MASK_CNT;
            phase_d   = PH_MASK;
          end
        end
        PH_MASK: begin
          mkey_d    = {mkey_q[23:0], byte_i};
          ext_cnt_d = ext_cnt_q - 4'd1;
          if (ext_cnt_d == 4'd0) begin
            midx_d = 2'd0;
            if (len_q == 64'd0) begin
              phase_d    = PH_OPCODE;
              res_o.valid = 1'b1;
              res_o.kind  = KIND_EMPTY;
            end else begin
              phase_d = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          len_d       = len_q - 64'd1;
          midx_d      = midx_q + 2'd1;
          res_o.valid = 1'b1;
          res_o.kind  = KIND_DATA;
          res_o.data  = byte_i ^ mbyte;
          res_o.last  = (len_q == 64'd1);
          if (len_q == 64'd1) begin
            phase_d = PH_OPCODE;
          end
        end
        default: begin
          phase_d = PH_OPCODE;
          case (byte_i[3:0])
            OP_TEXT:  phase_d = PH_LENGTH;
            OP_CONT:  ;
            OP_CLOSE: begin
              res_o.valid = 1'b1;
              res_o.kind  = KIND_CLOSE;
            end
            default: begin
              res_o.valid = 1'b1;
              res_o.kind  = KIND_ERROR;
            end
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_OPCODE;
      ext_cnt_q <= '0;
      len_q     <= '0;
      mkey_q    <= '0;
      midx_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      ext_cnt_q <= ext_cnt_d;
      len_q     <= len_d;
      mkey_q    <= mkey_d;
      midx_q    <= midx_d;
    end
  end

  `WSD_ASSERT_IMPL(a_cnt_live, (phase_q == PH_EXT) || (phase_q == PH_MASK), ext_cnt_q != 4'd0)
  `WSD_ASSERT_IMPL(a_len_live, phase_q == PH_PAYLOAD, len_q != 64'd0)
  `WSD_ASSERT(a_last_data, !res_o.last || (res_o.valid && res_o.kind == KIND_DATA))

endmodule
